[rtl/lamport_mutex_node_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the mutual exclusion node
// Shared macros so that every checker reports in the same way.
// ----------------------------------------------------------------------------
`ifndef LAMPORT_MUTEX_NODE_CORE_DEFINES_SVH
`define LAMPORT_MUTEX_NODE_CORE_DEFINES_SVH

// Check that the consequent holds in the cycle after the antecedent
`define LMN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Check that the consequent holds in the same cycle as the antecedent
`define LMN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

[rtl/lmn_pkg.sv]
// ----------------------------------------------------------------------------
// lmn_pkg
// Types, codes and helpers shared by the mutual exclusion node modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmn_pkg;

    localparam int DEF_MAX_NODES   = 4;
    localparam int DEF_CLOCK_WIDTH = 32;

    // command codes
    localparam logic [1:0] CMD_REQUEST = 2'd0;
    localparam logic [1:0] CMD_RECEIVE = 2'd1;
    localparam logic [1:0] CMD_CHECK   = 2'd2;

    // message kinds
    localparam logic [1:0] MSG_REQUEST = 2'd0;
    localparam logic [1:0] MSG_RELEASE = 2'd1;
    localparam logic [1:0] MSG_ACK     = 2'd2;

    // result events
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_MSG   = 2'd1;
    localparam logic [1:0] EV_GRANT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_NODE_ID    = 2'd0;
    localparam logic [1:0] CFG_NODE_COUNT = 2'd1;
    localparam logic [1:0] CFG_QUOTA      = 2'd2;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_REQUEST = 2'd1,
        OP_RECEIVE = 2'd2,
        OP_CHECK   = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  from;
        logic [31:0] ts;
        logic [1:0]  kind;
    } item_t;

    typedef struct packed {
        logic [3:0] node_id;
        logic [4:0] node_count;
        logic [7:0] quota;
        logic       quota_wr;
    } cfg_t;

    // active node count: the smaller of the configured and built sizes
    function automatic logic [4:0] active_count(input logic [4:0] nc,
                                                input logic [4:0] maxn);
        active_count = (nc < maxn) ? nc : maxn;
    endfunction

endpackage

[rtl/lamport_mutex_node_core.sv]
// ----------------------------------------------------------------------------
// lamport_mutex_node_core
// One node of a timestamp-ordered distributed mutual exclusion scheme.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the in_valid/in_stall channel (cmd, msg_from,
//   msg_timestamp, msg_kind); a two-entry queue takes up to two requests
//   ahead of the execution engine. Results leave on out_valid/out_stall,
//   one registered result per cycle at most, with last set on the final
//   result of each command. Configuration writes use cfg_valid/cfg_ready
//   (always ready); the user must make them only while the node is idle,
//   as the block itself does not enforce this. Engine steps per command:
//   a request sends one message to each other active node; a receive
//   updates the clock and tables, then acknowledges a request; a grant
//   check reads its own request time, walks the table with a wait for each
//   registered read of the request time memory, then grants and fans out
//   the release. A check that fails ends with its empty result.
//   Reset clears the clock, request flags and sequence counters at once and
//   loads node_id 0, node_count 3 and a quota of one use.
//   A stalled receiver holds the output register; the engine waits on it
//   while the queue keeps taking commands until full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lamport_mutex_node_core import lmn_pkg::*; #(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int CLOCK_WIDTH = DEF_CLOCK_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [3:0]  msg_from,
    input  logic [31:0] msg_timestamp,
    input  logic [1:0]  msg_kind,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_res,
    output logic [3:0]  dest,
    output logic [1:0]  out_kind,
    output logic [31:0] out_timestamp,
    output logic [31:0] out_seq,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [3:0] node_id_reg;
    logic [4:0] node_count_reg;
    cfg_t       cfg;
    logic       q_valid, q_pop;
    item_t      q_item;
    logic       cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // configuration registers; a quota write goes straight to the engine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg    <= 4'd0;
            node_count_reg <= 5'd3;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_NODE_ID:    node_id_reg    <= cfg_data[3:0];
                CFG_NODE_COUNT: node_count_reg <= cfg_data[4:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        cfg.node_id    = node_id_reg;
        cfg.node_count = node_count_reg;
        cfg.quota      = cfg_data;
        cfg.quota_wr   = cfg_wr && (cfg_index == CFG_QUOTA);
    end

    lmn_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .msg_from      (msg_from),
        .msg_timestamp (msg_timestamp),
        .msg_kind      (msg_kind),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    lmn_back #(
        .MAX_NODES   (MAX_NODES),
        .CLOCK_WIDTH (CLOCK_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .dest          (dest),
        .out_kind      (out_kind),
        .out_timestamp (out_timestamp),
        .out_seq       (out_seq),
        .last          (last)
    );

endmodule

[rtl/lmn_ram.sv]
// ----------------------------------------------------------------------------
// lmn_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/lmn_front.sv]
// ----------------------------------------------------------------------------
// lmn_front
// Accepts commands, classifies them against the configuration and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmn_front import lmn_pkg::*; #(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [3:0]  msg_from,
    input  logic [31:0] msg_timestamp,
    input  logic [1:0]  msg_kind,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t      slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_reg, rd_reg;
    logic       push;
    logic [4:0] na;
    logic       own_ok, from_ok;
    item_t      cls;

    // classify the incoming request
    always_comb
    begin
        na      = active_count(cfg.node_count, 5'(MAX_NODES));
        own_ok  = {1'b0, cfg.node_id} < na;
        from_ok = ({1'b0, msg_from} < na) && (msg_from != cfg.node_id);
        cls.from = msg_from;
        cls.ts   = msg_timestamp;
        cls.kind = msg_kind;
        case (cmd)
            CMD_REQUEST: cls.op = own_ok ? OP_REQUEST : OP_NONE;
            CMD_RECEIVE: cls.op = from_ok ? OP_RECEIVE : OP_NONE;
            CMD_CHECK:   cls.op = own_ok ? OP_CHECK : OP_NONE;
            default:     cls.op = OP_NONE;
        endcase
    end

    assign in_stall = cnt_reg[1];
    assign push     = in_valid && !in_stall;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_item   = slot_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (q_pop)
            begin
                rd_reg <= !rd_reg;
            end
        end
    end

    // hold queued payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= cls;
        end
    end

endmodule

[rtl/lmn_back.sv]
// ----------------------------------------------------------------------------
// lmn_back
// Executes queued operations: clock, node tables, grant test and messages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmn_back import lmn_pkg::*; #(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int CLOCK_WIDTH = DEF_CLOCK_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_res,
    output logic [3:0]  dest,
    output logic [1:0]  out_kind,
    output logic [31:0] out_timestamp,
    output logic [31:0] out_seq,
    output logic        last
);

    localparam int NIW = $clog2(MAX_NODES);
    localparam int RTW = (CLOCK_WIDTH > 32) ? CLOCK_WIDTH : 32;
    localparam int WW  = RTW + 1;
    localparam logic [CLOCK_WIDTH-1:0] CMAX = {CLOCK_WIDTH{1'b1}};

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RECV  = 13'b0000000000010,
        S_REL   = 13'b0000000000100,
        S_ACK   = 13'b0000000001000,
        S_CHKW  = 13'b0000000010000,
        S_CHKT  = 13'b0000000100000,
        S_SCANW = 13'b0000001000000,
        S_SCAN  = 13'b0000010000000,
        S_GRANT = 13'b0000100000000,
        S_SEND  = 13'b0001000000000,
        S_FIN   = 13'b0010000000000,
        S_NULL  = 13'b0100000000000,
        S_SPARE = 13'b1000000000000
    } state_t;

    state_t                 state_reg, state_next;
    item_t                  item_reg, item_next;
    logic [NIW-1:0]         cur_reg, cur_next;
    logic [1:0]             kind_reg, kind_next;
    logic                   sent_reg, sent_next;
    logic [CLOCK_WIDTH-1:0] clock_reg, clock_next;
    logic                   asking_reg, asking_next;
    logic [7:0]             uses_reg, uses_next;
    logic [MAX_NODES-1:0]   rv_reg, rv_next;
    logic [MAX_NODES-1:0]   heard_reg, heard_next;
    logic [31:0]            ms_reg [MAX_NODES];
    logic [31:0]            ms_next [MAX_NODES];
    logic [31:0]            seq_reg [MAX_NODES];
    logic [31:0]            seq_next [MAX_NODES];
    logic [RTW-1:0]         t_reg, t_next;

    logic        out_valid_reg;
    logic [1:0]  ev_reg;
    logic [3:0]  dest_reg;
    logic [1:0]  okind_reg;
    logic [31:0] ots_reg, oseq_reg;
    logic        last_reg;

    logic        emit;
    logic [1:0]  e_ev, e_kind;
    logic [3:0]  e_dest;
    logic [31:0] e_ts, e_seq;
    logic        e_last;

    logic                   ram_we;
    logic [NIW-1:0]         ram_waddr;
    logic [RTW-1:0]         ram_wdata, rt_q;

    logic [4:0]             na, c1;
    logic [3:0]             cur4;
    logic                   is_me, at_end, final_msg, free, fail;
    logic [NIW-1:0]         me;
    logic [CLOCK_WIDTH-1:0] clock_tick;
    logic [WW-1:0]          a_w, b_w, ts_w, cmax_w, m_w, clk_w;
    logic [31:0]            seq_inc;

    lmn_ram #(
        .WIDTH (RTW),
        .DEPTH (MAX_NODES)
    ) u_rtime (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cur_reg),
        .rdata (rt_q)
    );

    // decode loop position and clock arithmetic
    always_comb
    begin
        na         = active_count(cfg.node_count, 5'(MAX_NODES));
        cur4       = 4'(cur_reg);
        me         = cfg.node_id[NIW-1:0];
        is_me      = cur4 == cfg.node_id;
        c1         = 5'(cur_reg) + 5'd1;
        at_end     = c1 >= na;
        final_msg  = at_end || ((c1 == {1'b0, cfg.node_id}) && ((c1 + 5'd1) >= na));
        free       = !out_valid_reg || !out_stall;
        clock_tick = (clock_reg == CMAX) ? clock_reg : clock_reg + CLOCK_WIDTH'(1);
        a_w        = WW'(clock_tick);
        ts_w       = WW'(item_reg.ts);
        cmax_w     = WW'(CMAX);
        b_w        = (ts_w < cmax_w) ? ts_w + WW'(1) : cmax_w;
        m_w        = (a_w > b_w) ? a_w : b_w;
        clk_w      = WW'(clock_reg);
        seq_inc    = seq_reg[cur_reg] + 32'd1;
        fail       = !is_me &&
                     ((rv_reg[cur_reg] && ((rt_q < t_reg) ||
                                           ((rt_q == t_reg) && (cur4 < cfg.node_id)))) ||
                      !heard_reg[cur_reg] ||
                      (RTW'(ms_reg[cur_reg]) <= t_reg));
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        cur_next    = cur_reg;
        kind_next   = kind_reg;
        sent_next   = sent_reg;
        clock_next  = clock_reg;
        asking_next = asking_reg;
        uses_next   = uses_reg;
        rv_next     = rv_reg;
        heard_next  = heard_reg;
        ms_next     = ms_reg;
        seq_next    = seq_reg;
        t_next      = t_reg;
        q_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = cur_reg;
        ram_wdata   = RTW'(item_reg.ts);
        emit        = 1'b0;
        e_ev        = EV_NONE;
        e_dest      = 4'd0;
        e_kind      = MSG_REQUEST;
        e_ts        = 32'd0;
        e_seq       = 32'd0;
        e_last      = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    sent_next = 1'b0;
                    case (q_item.op)
                        OP_REQUEST:
                        begin
                            if (!asking_reg && (uses_reg != 8'd0))
                            begin
                                asking_next = 1'b1;
                                rv_next[me] = 1'b1;
                                ram_we      = 1'b1;
                                ram_waddr   = me;
                                ram_wdata   = RTW'(clock_reg);
                                kind_next   = MSG_REQUEST;
                                cur_next    = '0;
                                state_next  = S_SEND;
                            end
                            else
                            begin
                                state_next = S_NULL;
                            end
                        end
                        OP_RECEIVE:
                        begin
                            cur_next   = q_item.from[NIW-1:0];
                            state_next = S_RECV;
                        end
                        OP_CHECK:
                        begin
                            cur_next   = me;
                            state_next = asking_reg ? S_CHKW : S_NULL;
                        end
                        default: state_next = S_NULL;
                    endcase
                end
            end
            S_RECV:
            begin
                clock_next = m_w[CLOCK_WIDTH-1:0];
                if (!heard_reg[cur_reg] || (item_reg.ts > ms_reg[cur_reg]))
                begin
                    ms_next[cur_reg] = item_reg.ts;
                end
                heard_next[cur_reg] = 1'b1;
                if (item_reg.kind == MSG_REQUEST)
                begin
                    rv_next[cur_reg] = 1'b1;
                    ram_we           = 1'b1;
                    state_next       = S_ACK;
                end
                else if (item_reg.kind == MSG_RELEASE)
                begin
                    state_next = S_REL;
                end
                else
                begin
                    state_next = S_NULL;
                end
            end
            S_REL:
            begin
                if (rv_reg[cur_reg] && (rt_q <= RTW'(item_reg.ts)))
                begin
                    rv_next[cur_reg] = 1'b0;
                end
                state_next = S_NULL;
            end
            S_ACK:
            begin
                if (free)
                begin
                    emit              = 1'b1;
                    e_ev              = EV_MSG;
                    e_dest            = cur4;
                    e_kind            = MSG_ACK;
                    e_ts              = clk_w[31:0];
                    e_seq             = seq_inc;
                    seq_next[cur_reg] = seq_inc;
                    clock_next        = clock_tick;
                    state_next        = S_IDLE;
                end
            end
            S_CHKW:
            begin
                state_next = rv_reg[cur_reg] ? S_CHKT : S_NULL;
            end
            S_CHKT:
            begin
                t_next     = rt_q;
                cur_next   = '0;
                state_next = S_SCANW;
            end
            S_SCANW:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (fail)
                begin
                    state_next = S_NULL;
                end
                else if (at_end)
                begin
                    state_next = S_GRANT;
                end
                else
                begin
                    cur_next   = cur_reg + NIW'(1);
                    state_next = S_SCANW;
                end
            end
            S_GRANT:
            begin
                if (free)
                begin
                    emit        = 1'b1;
                    e_ev        = EV_GRANT;
                    e_dest      = cfg.node_id;
                    e_ts        = clk_w[31:0];
                    e_last      = na < 5'd2;
                    uses_next   = (uses_reg != 8'd0) ? uses_reg - 8'd1 : 8'd0;
                    clock_next  = clock_tick;
                    rv_next[me] = 1'b0;
                    sent_next   = 1'b1;
                    cur_next    = '0;
                    kind_next   = MSG_RELEASE;
                    state_next  = S_SEND;
                end
            end
            S_SEND:
            begin
                if (is_me || free)
                begin
                    if (!is_me)
                    begin
                        emit              = 1'b1;
                        e_ev              = EV_MSG;
                        e_dest            = cur4;
                        e_kind            = kind_reg;
                        e_ts              = clk_w[31:0];
                        e_seq             = seq_inc;
                        e_last            = final_msg;
                        seq_next[cur_reg] = seq_inc;
                        clock_next        = clock_tick;
                        sent_next         = 1'b1;
                    end
                    if (at_end)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cur_next = cur_reg + NIW'(1);
                    end
                end
            end
            S_FIN:
            begin
                clock_next = clock_tick;
                if (kind_reg == MSG_RELEASE)
                begin
                    asking_next = 1'b0;
                end
                state_next = sent_reg ? S_IDLE : S_NULL;
            end
            S_NULL:
            begin
                if (free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // a quota write reloads the remaining uses
        if (cfg.quota_wr)
        begin
            uses_next = cfg.quota;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clock_reg     <= '0;
            asking_reg    <= 1'b0;
            uses_reg      <= 8'd1;
            rv_reg        <= '0;
            heard_reg     <= '0;
            seq_reg       <= '{default: 32'd0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clock_reg  <= clock_next;
            asking_reg <= asking_next;
            uses_reg   <= uses_next;
            rv_reg     <= rv_next;
            heard_reg  <= heard_next;
            seq_reg    <= seq_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        cur_reg  <= cur_next;
        kind_reg <= kind_next;
        sent_reg <= sent_next;
        ms_reg   <= ms_next;
        t_reg    <= t_next;
        if (emit)
        begin
            ev_reg    <= e_ev;
            dest_reg  <= e_dest;
            okind_reg <= e_kind;
            ots_reg   <= e_ts;
            oseq_reg  <= e_seq;
            last_reg  <= e_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = ev_reg;
    assign dest          = dest_reg;
    assign out_kind      = okind_reg;
    assign out_timestamp = ots_reg;
    assign out_seq       = oseq_reg;
    assign last          = last_reg;

endmodule

[rtl/lmn_checker.sv]
// ----------------------------------------------------------------------------
// lmn_checker
// Port-level checks on the result channel of the mutual exclusion node.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lamport_mutex_node_core_defines.svh"

module lmn_checker import lmn_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  event_res,
    input logic [1:0]  out_kind,
    input logic [31:0] out_timestamp,
    input logic [31:0] out_seq,
    input logic        last
);

    // hold a stalled result
    `LMN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `LMN_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_seq) && $stable(last))
    // an empty result closes its command and carries nothing
    `LMN_ASSERT_NOW(a_none_last, out_valid && (event_res == EV_NONE),
                    last && (out_timestamp == 32'd0) && (out_seq == 32'd0))
    // a grant carries no sequence number and no message kind
    `LMN_ASSERT_NOW(a_grant_fields, out_valid && (event_res == EV_GRANT),
                    (out_seq == 32'd0) && (out_kind == MSG_REQUEST))

endmodule

bind lamport_mutex_node_core lmn_checker u_lmn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_res     (event_res),
    .out_kind      (out_kind),
    .out_timestamp (out_timestamp),
    .out_seq       (out_seq),
    .last          (last)
);
